// ----- sv/pmlfu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmlfu_pkg
// Shared widths and types for the paged MMU with LFU frame replacement.
// ----------------------------------------------------------------------------
package pmlfu_pkg;

    localparam int ADDR_W      = 16;
    localparam int PHYS_W      = 15;
    localparam int FAULT_W     = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp_flags;

endpackage
`default_nettype wire

// ----- sv/page_table_mmu_lfu_replace.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_table_mmu_lfu_replace
// Paged MMU: maps a virtual address through a page map, replaces the least
// frequently used frame on a fault, and returns the physical address.
//
//  channel  dir  tdata                                  tuser
//  s_axis   in   virt_addr[15:0]                        -
//  m_axis   out  phys_addr[14:0], fault_total[30:15]    page_fault[0]
//
// Hit: RDPM, LOOKUP and INC (count increment) states, then OUT holds the result.
// Fault: RDPM and LOOKUP, then MIN (min search over the count RAM), SCAN (unmap
// scan over the page-map RAM, one entry per cycle through the ALU), FIN, OUT.
// A VIRT_PAGES that is not a power of two and below the page-number range
// adds a restoring mod step (MOD) over the page-number bits first.
// Reset is immediate: per-entry valid bits restore the map and the counts.
// One item at a time; s_axis_tready is low in reset and until the result is
// transferred.
// ----------------------------------------------------------------------------
module page_table_mmu_lfu_replace import pmlfu_pkg::*; #(
    parameter int VIRT_PAGES  = 16,
    parameter int FRAMES      = 8,
    parameter int OFFSET_BITS = 12,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // virt_addr[15:0]
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,   // phys_addr[14:0], fault_total[30:15]
    output logic      [0:0]             m_axis_tuser    // page_fault[0]
);

    localparam int FR_W    = $clog2(FRAMES);
    localparam int MAP_W   = $clog2(FRAMES + 1);
    localparam int PG_W    = $clog2(VIRT_PAGES);
    localparam int PRAW_W  = (OFFSET_BITS < ADDR_W) ? ADDR_W - OFFSET_BITS : 1;
    localparam bit PG_POW2 = ((VIRT_PAGES & (VIRT_PAGES - 1)) == 0);
    localparam bit NEED_MOD = !PG_POW2 && ((1 << PRAW_W) > VIRT_PAGES);
    localparam int KW      = $clog2(PRAW_W);
    localparam int CNT_A   = (PG_W > FR_W) ? PG_W : FR_W;
    localparam int CNT_W   = (CNT_A > KW) ? CNT_A : KW;
    localparam int CMP_A   = (COUNT_BITS > PG_W + PRAW_W) ? COUNT_BITS : PG_W + PRAW_W;
    localparam int CMP_W   = (CMP_A > MAP_W) ? CMP_A : MAP_W;
    localparam int PC_A    = OFFSET_BITS + FR_W;
    localparam int PC_W    = (PC_A > PHYS_W) ? PC_A : PHYS_W;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MOD    = 9'b000000010,
        ST_RDPM   = 9'b000000100,
        ST_LOOKUP = 9'b000001000,
        ST_MIN    = 9'b000010000,
        ST_SCAN   = 9'b000100000,
        ST_FIN    = 9'b001000000,
        ST_INC    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } t_state;

    t_state                r_state, n_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [PRAW_W-1:0]     r_rem;
    logic [CMP_W-1:0]      r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic [FR_W-1:0]       r_frame;
    logic [COUNT_BITS-1:0] r_best;
    logic [FAULT_W-1:0]    r_faults;
    logic [PHYS_W-1:0]     r_phys;
    logic                  r_fault;
    logic [VIRT_PAGES-1:0] r_pm_vld;
    logic [FRAMES-1:0]     r_fu_vld;
    logic [PG_W-1:0]       r_pm_ra;
    logic [FR_W-1:0]       r_fu_ra;

    logic [PG_W-1:0]       w_page;
    logic [MAP_W-1:0]      pm_rdata, pm_eff, pm_wdata;
    logic [COUNT_BITS-1:0] fu_rdata, fu_eff, fu_wdata;
    logic                  pm_hit, pm_we, fu_we;
    logic [PG_W-1:0]       pm_raddr, pm_waddr;
    logic [FR_W-1:0]       fu_raddr, fu_waddr;
    logic [CMP_W-1:0]      alu_a, alu_b, alu_diff;
    t_cmp_flags            alu_flags;
    logic                  min_last, scan_last, mod_last, take_min;
    logic [PC_W-1:0]       phys_full;
    logic                  in_xfer, out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {1'b0, r_faults, r_phys};
    assign m_axis_tuser  = r_fault;

    assign w_page = PG_W'(r_rem);

    // Entries never written read as their reset value
    assign pm_eff = r_pm_vld[r_pm_ra] ? pm_rdata :
                    ((int'(r_pm_ra) < FRAMES) ? MAP_W'(r_pm_ra) : MAP_W'(FRAMES));
    assign fu_eff = r_fu_vld[r_fu_ra] ? fu_rdata : '0;
    assign pm_hit = (pm_eff < MAP_W'(FRAMES));

    assign min_last  = (r_cnt == CNT_W'(FRAMES - 1));
    assign scan_last = (r_cnt == CNT_W'(VIRT_PAGES - 1));
    assign mod_last  = (r_cnt == CNT_W'(PRAW_W - 1));
    assign take_min  = (r_cnt == '0) || alu_flags.lt;

    assign phys_full = (PC_W'(r_frame) << OFFSET_BITS)
                     | (PC_W'(r_addr) & ((PC_W'(1) << OFFSET_BITS) - PC_W'(1)));

    always_comb begin
        alu_a = CMP_W'(fu_eff);
        alu_b = CMP_W'({COUNT_BITS{1'b1}});
        case (r_state)
            ST_MOD: begin
                alu_a = CMP_W'(r_rem);
                alu_b = r_div;
            end
            ST_MIN: begin
                alu_a = CMP_W'(fu_eff);
                alu_b = CMP_W'(r_best);
            end
            ST_SCAN: begin
                alu_a = CMP_W'(pm_eff);
                alu_b = CMP_W'(r_frame);
            end
            default: begin
                alu_a = CMP_W'(fu_eff);
                alu_b = CMP_W'({COUNT_BITS{1'b1}});
            end
        endcase
    end

    pmlfu_alu #(.WIDTH(CMP_W)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_diff  (alu_diff),
        .o_flags (alu_flags)
    );

    always_comb begin
        pm_raddr = w_page;
        fu_raddr = r_frame;
        pm_we    = 1'b0;
        pm_waddr = w_page;
        pm_wdata = MAP_W'(r_frame);
        fu_we    = 1'b0;
        fu_waddr = r_frame;
        fu_wdata = COUNT_BITS'(1);
        n_state  = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = NEED_MOD ? ST_MOD : ST_RDPM;
                end
            end
            ST_MOD: begin
                if (mod_last) begin
                    n_state = ST_RDPM;
                end
            end
            ST_RDPM: begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                fu_raddr = pm_hit ? pm_eff[FR_W-1:0] : '0;
                n_state  = pm_hit ? ST_INC : ST_MIN;
            end
            ST_MIN: begin
                fu_raddr = min_last ? '0 : FR_W'(r_cnt + CNT_W'(1));
                pm_raddr = '0;
                if (min_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                pm_raddr = scan_last ? '0 : PG_W'(r_cnt + CNT_W'(1));
                pm_we    = alu_flags.eq;
                pm_waddr = PG_W'(r_cnt);
                pm_wdata = MAP_W'(FRAMES);
                if (scan_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                pm_we   = 1'b1;
                fu_we   = 1'b1;
                n_state = ST_OUT;
            end
            ST_INC: begin
                fu_we    = 1'b1;
                fu_wdata = alu_flags.lt ? fu_eff + COUNT_BITS'(1) : fu_eff;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    pmlfu_ram #(.WIDTH(MAP_W), .DEPTH(VIRT_PAGES)) u_page_map (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    pmlfu_ram #(.WIDTH(COUNT_BITS), .DEPTH(FRAMES)) u_frame_uses (
        .i_clk   (i_clk),
        .i_we    (fu_we),
        .i_waddr (fu_waddr),
        .i_wdata (fu_wdata),
        .i_raddr (fu_raddr),
        .o_rdata (fu_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_pm_ra <= pm_raddr;
        r_fu_ra <= fu_raddr;
        case (r_state)
            ST_IDLE: begin
                r_addr <= s_axis_tdata;
                r_rem  <= PRAW_W'(s_axis_tdata >> OFFSET_BITS);
                r_div  <= CMP_W'(VIRT_PAGES) << (PRAW_W - 1);
                r_cnt  <= '0;
            end
            ST_MOD: begin
                if (!alu_flags.lt) begin
                    r_rem <= alu_diff[PRAW_W-1:0];
                end
                r_div <= r_div >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_LOOKUP: begin
                r_frame <= pm_eff[FR_W-1:0];
                r_cnt   <= '0;
            end
            ST_MIN: begin
                if (take_min) begin
                    r_best  <= fu_eff;
                    r_frame <= FR_W'(r_cnt);
                end
                r_cnt <= min_last ? '0 : r_cnt + CNT_W'(1);
            end
            ST_SCAN: begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            ST_FIN: begin
                r_phys  <= phys_full[PHYS_W-1:0];
                r_fault <= 1'b1;
            end
            ST_INC: begin
                r_phys  <= phys_full[PHYS_W-1:0];
                r_fault <= 1'b0;
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_faults <= '0;
            r_pm_vld <= '0;
            r_fu_vld <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_FIN && r_faults != {FAULT_W{1'b1}}) begin
                r_faults <= r_faults + FAULT_W'(1);
            end
            if (pm_we) begin
                r_pm_vld[pm_waddr] <= 1'b1;
            end
            if (fu_we) begin
                r_fu_vld[fu_waddr] <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/pmlfu_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmlfu_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pmlfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- sv/pmlfu_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmlfu_alu
// Shared subtract / compare unit used by the MOD, MIN, SCAN and INC steps.
// ----------------------------------------------------------------------------
module pmlfu_alu import pmlfu_pkg::*; #(
    parameter int WIDTH = 16
) (
    input  wire logic [WIDTH-1:0] i_a,
    input  wire logic [WIDTH-1:0] i_b,
    output logic      [WIDTH-1:0] o_diff,
    output t_cmp_flags            o_flags
);

    logic [WIDTH:0] w_sub;

    assign w_sub         = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff        = w_sub[WIDTH-1:0];
    assign o_flags.lt    = w_sub[WIDTH];
    assign o_flags.eq    = (i_a == i_b);

endmodule
`default_nettype wire

// ----- sv/pmlfu_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmlfu_chk
// Port-level checks: one item in flight, result hold, fault count progress.
// ----------------------------------------------------------------------------
module pmlfu_chk import pmlfu_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]             m_axis_tuser
);

    logic               r_seen;
    logic [FAULT_W-1:0] r_last;
    logic               in_xfer, out_xfer;
    logic [FAULT_W-1:0] total;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign total    = m_axis_tdata[PHYS_W+FAULT_W-1:PHYS_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_last <= '0;
        end else if (out_xfer) begin
            r_seen <= 1'b1;
            r_last <= total;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready && !m_axis_tvalid)
        else $error("input taken again before the item finished");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result is pending");

    a_total_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen && !m_axis_tuser[0] |-> total == r_last)
        else $error("fault total moved without a fault");

    a_total_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer && r_seen && m_axis_tuser[0] && r_last != {FAULT_W{1'b1}}
            |-> total == r_last + FAULT_W'(1))
        else $error("fault total did not step on a fault");

endmodule

bind page_table_mmu_lfu_replace pmlfu_chk u_pmlfu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
